// ===== design/sorted_priority_queue_assert.svh =====
// Assertion shorthands used by the queue datapath.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Condition that holds at every edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH_DEFAULT  = 64;
   localparam int FREQ_W         = 24;
   localparam int CHAR_W         = 8;
   localparam int PAYLOAD_W      = 10;
   localparam int ENTRY_COUNT_W  = 7;
   localparam int STATUS_W       = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [FREQ_W-1:0]    freq;
      logic [CHAR_W-1:0]    chr;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_RD,
      ST_RESULT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture request, set index to count
      logic rd_en;      // read memory
      logic rd_prev;    // read at index-1, else at the front
      logic wr_en;      // write memory at index
      logic wr_new;     // write the new entry, else the entry just read
      logic idx_dec;    // step index down
      logic finish;     // load the response, update count and head
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic idx_zero;
      logic idx_one;
      logic key_after;  // new key sorts after the entry just read
      logic rsp_free;
   } stat_type;

endpackage

// ===== design/sorted_priority_queue.sv =====
// Ascending priority queue of {frequency, character, payload} entries.
// Request channel (req_*): operation 0 inserts the entry in key order
// (frequency, then character; a new entry goes ahead of equal keys),
// operation 1 removes the smallest entry. Every request gives exactly one
// response on rsp_*: the removed entry (zeros otherwise), removed_valid,
// the entry count afterwards and a status (ok, full, empty).
// One request is worked at a time. Entries sit in a single-port-style
// memory used as a ring, read and written one slot per cycle.
// Each accepted request passes a dispatch step. A refused one then goes
// to the result step, a remove reads the front entry first, and an insert
// walks down from the top, one read and one compare per entry examined and
// a write for each entry moved up, before it writes the new entry; that
// sweep is the longest path. The next request is taken in the cycle after
// the response is loaded. req_ready is high while no request is being
// worked, even when a finished response still waits; if rsp_ready stays
// low the next response holds in its final step until the output register
// frees.
// Reset (synchronous) empties the queue at once: count and head go to zero.
// The memory is not cleared, as slots are never read before being written.
module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [spq_pkg::FREQ_W-1:0]           req_frequency,
   input  logic [spq_pkg::CHAR_W-1:0]           req_tie_char,
   input  logic [spq_pkg::PAYLOAD_W-1:0]        req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [spq_pkg::FREQ_W-1:0]           rsp_out_frequency,
   output logic [spq_pkg::CHAR_W-1:0]           rsp_out_char,
   output logic [spq_pkg::PAYLOAD_W-1:0]        rsp_out_payload,
   output logic                                 rsp_removed_valid,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count,
   output logic [spq_pkg::STATUS_W-1:0]         rsp_status
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_frequency     (req_frequency),
      .req_tie_char      (req_tie_char),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_frequency (rsp_out_frequency),
      .rsp_out_char      (rsp_out_char),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== design/spq_ctrl.sv =====
module spq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  spq_pkg::stat_type  stat,
   output spq_pkg::cmd_type   cmd
);
   import spq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            priority if (stat.is_remove && stat.empty) state_in = ST_RESULT;
            else if (stat.is_remove)                   state_in = ST_REM_RD;
            else if (stat.full)                        state_in = ST_RESULT;
            else if (stat.idx_zero)                    state_in = ST_INS_PUT;
            else                                       state_in = ST_INS_RD;
         end
         ST_INS_RD:  state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            // stop once the new key sorts after the stored one or the front is reached
            if (stat.key_after || stat.idx_one) state_in = ST_INS_PUT;
            else                                state_in = ST_INS_RD;
         end
         ST_INS_PUT: state_in = ST_RESULT;
         ST_REM_RD:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DISPATCH: ;
         ST_INS_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
         end
         ST_INS_CMP: begin
            // shift the stored entry up one place
            cmd.wr_en   = !stat.key_after;
            cmd.idx_dec = !stat.key_after;
         end
         ST_INS_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
         end
         ST_REM_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_RESULT: begin
            cmd.finish = stat.rsp_free;
         end
         default: ;
      endcase
   end

endmodule

// ===== design/spq_datapath.sv =====
`include "sorted_priority_queue_assert.svh"

module spq_datapath #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spq_pkg::cmd_type                     cmd,
   output spq_pkg::stat_type                    stat,
   input  logic                                 req_operation,
   input  logic [spq_pkg::FREQ_W-1:0]           req_frequency,
   input  logic [spq_pkg::CHAR_W-1:0]           req_tie_char,
   input  logic [spq_pkg::PAYLOAD_W-1:0]        req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [spq_pkg::FREQ_W-1:0]           rsp_out_frequency,
   output logic [spq_pkg::CHAR_W-1:0]           rsp_out_char,
   output logic [spq_pkg::PAYLOAD_W-1:0]        rsp_out_payload,
   output logic                                 rsp_removed_valid,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count,
   output logic [spq_pkg::STATUS_W-1:0]         rsp_status
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // request hold
   logic      req_op_ff;
   entry_type new_ff;

   // queue state: ring buffer from head_ff, count_ff entries sorted ascending
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   logic [CW-1:0] rd_off;
   logic [AW:0]   rd_sum, wr_sum;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     wr_data;

   logic rsp_valid_ff, rsp_valid_in;
   entry_type             rsp_entry_ff, rsp_entry_in;
   logic                  rsp_removed_ff, rsp_removed_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   always_comb begin
      stat.is_remove = (req_op_ff == OP_REMOVE);
      stat.full      = (count_ff == CW'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.idx_zero  = (idx_ff == '0);
      stat.idx_one   = (idx_ff == CW'(1));
      stat.key_after = (new_ff.freq > rd_data_ff.freq) ||
                       ((new_ff.freq == rd_data_ff.freq) && (new_ff.chr > rd_data_ff.chr));
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // logical slot -> physical address, wrapping once around the ring
   always_comb begin
      rd_off  = cmd.rd_prev ? (idx_ff - CW'(1)) : '0;
      rd_sum  = {1'b0, head_ff} + (AW+1)'(rd_off);
      wr_sum  = {1'b0, head_ff} + (AW+1)'(idx_ff);
      rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : rd_sum[AW-1:0];
      wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : wr_sum[AW-1:0];
      wr_data = cmd.wr_new ? new_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_op_ff      <= req_operation;
         new_ff.freq    <= req_frequency;
         new_ff.chr     <= req_tie_char;
         new_ff.payload <= req_payload;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req)     idx_in = count_ff;
      else if (cmd.idx_dec) idx_in = idx_ff - CW'(1);
   end

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      rsp_entry_in   = '0;
      rsp_removed_in = 1'b0;
      rsp_status_in  = STATUS_OK;
      if (stat.is_remove) begin
         if (stat.empty) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_entry_in   = rd_data_ff;
            rsp_removed_in = 1'b1;
            count_in       = count_ff - CW'(1);
            head_in        = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
         end
      end else begin
         if (stat.full) rsp_status_in = STATUS_FULL;
         else           count_in      = count_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.finish) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_entry_ff   <= rsp_entry_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_count_ff   <= ENTRY_COUNT_W'(count_in);
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_frequency = rsp_entry_ff.freq;
   assign rsp_out_char      = rsp_entry_ff.chr;
   assign rsp_out_payload   = rsp_entry_ff.payload;
   assign rsp_removed_valid = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   `SPQ_ASSERT_ALWAYS(a_count_range, count_ff <= CW'(DEPTH), "entry count beyond depth")
   `SPQ_ASSERT_ALWAYS(a_head_range, head_ff <= AW'(DEPTH - 1), "head pointer beyond depth")
   `SPQ_ASSERT_NEXT(a_insert_grows, cmd.finish && !stat.is_remove && !stat.full, count_ff == $past(count_ff) + CW'(1), "insert did not grow the queue")
   `SPQ_ASSERT_IMPL(a_removed_ok, rsp_valid_ff && rsp_removed_ff, rsp_status_ff == STATUS_OK, "removal reported with a failure status")
   `SPQ_ASSERT_IMPL(a_write_in_range, cmd.wr_en, idx_ff < CW'(DEPTH) && !stat.full, "memory write with no free slot")

endmodule
